/* hdl/laser_scan_grid_marker_defines.svh */
// ----------------------------------------------------------------------------
// Laser scan grid marker assertion macros
// Shared concurrent assertion forms, sampled on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef LASER_SCAN_GRID_MARKER_DEFINES_SVH
`define LASER_SCAN_GRID_MARKER_DEFINES_SVH

// same-cycle implication
`define LSGM_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsgm: assertion failed");

// next-cycle implication
`define LSGM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsgm: assertion failed");

`endif

/* hdl/lsgm_pkg.sv */
// ----------------------------------------------------------------------------
// Laser scan grid marker package
// Widths, register codes, word types and CORDIC constants.
// ----------------------------------------------------------------------------
package lsgm_pkg;

   localparam int RANGE_W     = 16;
   localparam int BEAM_W      = 12;
   localparam int COORD_W     = 7;
   localparam int STEP_W      = 24;
   localparam int RESID_W     = 22;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 24;

   localparam int GRID_W_DEF    = 128;
   localparam int GRID_H_DEF    = 128;
   localparam int MAX_BEAMS_DEF = 4096;

   localparam int CORDIC_ITERS = 16;
   localparam int DIV_BITS     = 16;
   localparam int FIFO_DEPTH   = 4;

   localparam logic [15:0] RANGE_MIN_RST  = 16'd100;
   localparam logic [15:0] RANGE_MAX_RST  = 16'd30000;
   localparam logic [23:0] ANGLE_STEP_RST = 24'd46603;
   localparam logic [15:0] CELL_SIZE_RST  = 16'd100;

   localparam logic signed [17:0] CORDIC_X0 = 18'sd19898;

   localparam logic [21:0] ATAN_TABLE [CORDIC_ITERS] = '{
      22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
      22'd166669,  22'd83416,   22'd41718,  22'd20860,
      22'd10430,   22'd5215,    22'd2608,   22'd1304,
      22'd652,     22'd326,     22'd163,    22'd81
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_MIN  = 8'd0,
      CSR_RANGE_MAX  = 8'd1,
      CSR_ANGLE_STEP = 8'd2,
      CSR_CELL_SIZE  = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] rng_lo;
      logic [15:0] rng_hi;
      logic [23:0] angle_step;
      logic [15:0] cell_size;
   } cfg_type;

   typedef struct packed {
      logic               cmd;
      logic               ok;
      logic [1:0]         quad;
      logic [RESID_W-1:0] resid;
      logic [RANGE_W-1:0] range_mm;
      logic [COORD_W-1:0] read_x;
      logic [COORD_W-1:0] read_y;
   } item_type;

   function automatic logic signed [15:0] sat15(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

/* hdl/lsgm_ifs.sv */
// ----------------------------------------------------------------------------
// Laser scan grid marker channels
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface lsgm_req_if import lsgm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic               range_finite;
   logic [RANGE_W-1:0] range_mm;
   logic [BEAM_W-1:0]  beam_index;
   logic [COORD_W-1:0] read_x;
   logic [COORD_W-1:0] read_y;
   modport source (output valid, cmd, range_finite, range_mm, beam_index, read_x, read_y,
                   input ready);
   modport sink (input valid, cmd, range_finite, range_mm, beam_index, read_x, read_y,
                 output ready);
endinterface

interface lsgm_rsp_if import lsgm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               marked;
   logic [COORD_W-1:0] cell_x;
   logic [COORD_W-1:0] cell_y;
   logic               cell_occupied;
   modport source (output valid, marked, cell_x, cell_y, cell_occupied, input ready);
   modport sink (input valid, marked, cell_x, cell_y, cell_occupied, output ready);
endinterface

interface lsgm_csr_if import lsgm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/lsgm_fifo.sv */
// ----------------------------------------------------------------------------
// Laser scan grid marker queue
// Short word queue between front and back.
// ----------------------------------------------------------------------------
module lsgm_fifo import lsgm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     in_ready,
   input  logic     pop,
   output logic     out_valid,
   output item_type out_data
);

   localparam int PW = $clog2(FIFO_DEPTH);

   item_type          slot_ff [FIFO_DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW:0]       count_ff;
   logic              do_push;
   logic              do_pop;

   assign in_ready  = (count_ff != (PW+1)'(FIFO_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push & in_ready;
   assign do_pop    = pop & out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* hdl/lsgm_front.sv */
// ----------------------------------------------------------------------------
// Laser scan grid marker front
// Accepts words, checks range and beam limits, forms the beam phase.
// ----------------------------------------------------------------------------
module lsgm_front import lsgm_pkg::*; #(
   parameter int MAX_BEAMS = MAX_BEAMS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     hold,
   lsgm_req_if.sink req_bus,
   output logic     push,
   output item_type push_data,
   input  logic     q_ready
);

   logic        front_valid_ff;
   item_type    front_item_ff;
   item_type    item_in;
   logic        load;
   logic [35:0] phase_prod;

   assign req_bus.ready = !hold && (!front_valid_ff || q_ready);
   assign load          = req_bus.valid && req_bus.ready;
   assign push          = front_valid_ff;
   assign push_data     = front_item_ff;
   assign phase_prod    = 36'(req_bus.beam_index) * 36'(cfg.angle_step);

   always_comb begin
      item_in          = '0;
      item_in.cmd      = req_bus.cmd;
      item_in.ok       = !req_bus.cmd && req_bus.range_finite
                         && (req_bus.range_mm > cfg.rng_lo)
                         && (req_bus.range_mm < cfg.rng_hi)
                         && (32'(req_bus.beam_index) < 32'(MAX_BEAMS));
      item_in.quad     = phase_prod[23:22];
      item_in.resid    = phase_prod[21:0];
      item_in.range_mm = req_bus.range_mm;
      item_in.read_x   = req_bus.read_x;
      item_in.read_y   = req_bus.read_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (load) begin
         front_valid_ff <= 1'b1;
      end else if (q_ready) begin
         front_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) front_item_ff <= item_in;
   end

endmodule

/* hdl/lsgm_back.sv */
// ----------------------------------------------------------------------------
// Laser scan grid marker back
// CORDIC, scaling, cell division, grid store and result register.
// ----------------------------------------------------------------------------
`include "laser_scan_grid_marker_defines.svh"

module lsgm_back import lsgm_pkg::*; #(
   parameter int GRID_W = GRID_W_DEF,
   parameter int GRID_H = GRID_H_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_take,
   output logic       clr_busy,
   lsgm_rsp_if.source rsp_bus
);

   localparam int DEPTH = GRID_W * GRID_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(GRID_W);
   localparam int YW    = $clog2(GRID_H);
   localparam int NI    = CORDIC_ITERS;
   localparam int NQ    = DIV_BITS;
   localparam logic [AW-1:0] GW_A = AW'(GRID_W);

   logic adv;

   // cordic stages
   logic                cv_ff [0:NI];
   item_type            cm_ff [0:NI];
   logic signed [17:0]  cx_ff [0:NI];
   logic signed [17:0]  cy_ff [0:NI];
   logic signed [24:0]  cz_ff [0:NI];

   // quadrant fold
   logic                tv_ff;
   item_type            tm_ff;
   logic signed [16:0]  tc_ff;
   logic signed [16:0]  ts_ff;
   logic signed [15:0]  sx;
   logic signed [15:0]  sy;
   logic signed [16:0]  tc_in;
   logic signed [16:0]  ts_in;

   // divider stages, lane 0 is x, lane 1 is y
   logic                dv_ff  [0:NQ];
   item_type            dm_ff  [0:NQ];
   logic [15:0]         dn_ff  [0:NQ][2];
   logic [15:0]         dr_ff  [0:NQ][2];
   logic [15:0]         dq_ff  [0:NQ][2];
   logic                dsg_ff [0:NQ][2];
   logic [16:0]         trial  [0:NQ-1][2];
   logic [15:0]         den;
   logic [15:0]         mag    [2];
   logic [31:0]         prod   [2];

   // address stage
   logic                av_ff;
   logic                a_cmd_ff;
   logic                a_mark_ff;
   logic                a_rdok_ff;
   logic [AW-1:0]       a_addr_ff;
   logic [COORD_W-1:0]  a_x_ff;
   logic [COORD_W-1:0]  a_y_ff;
   logic signed [19:0]  pos    [2];
   logic                in_x;
   logic                in_y;
   logic                mark_in;
   logic                rdok_in;
   logic [AW-1:0]       addr_in;

   // grid store and result
   logic                grid_mem [DEPTH];
   logic                grid_q_ff;
   logic                clr_busy_ff;
   logic [AW-1:0]       clr_cnt_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   logic                rsp_valid_ff;
   logic                rsp_marked_ff;
   logic                rsp_rd_ff;
   logic [COORD_W-1:0]  rsp_x_ff;
   logic [COORD_W-1:0]  rsp_y_ff;

   assign adv      = !rsp_valid_ff || rsp_bus.ready;
   assign q_take   = adv && !clr_busy_ff;
   assign clr_busy = clr_busy_ff;
   assign den      = (cfg.cell_size == '0) ? 16'd1 : cfg.cell_size;

   // ---- cordic ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= q_valid && !clr_busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cm_ff[0] <= q_item;
         cx_ff[0] <= CORDIC_X0;
         cy_ff[0] <= '0;
         cz_ff[0] <= $signed({3'b000, q_item.resid});
      end
   end

   for (genvar i = 0; i < NI; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cm_ff[i+1] <= cm_ff[i];
            if (!cz_ff[i][24]) begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - $signed({3'b000, ATAN_TABLE[i]});
            end else begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + $signed({3'b000, ATAN_TABLE[i]});
            end
         end
      end
   end

   // ---- saturate and fold quadrant ----
   always_comb begin
      sx = sat15(cx_ff[NI]);
      sy = sat15(cy_ff[NI]);
      case (cm_ff[NI].quad)
         2'd0: begin
            tc_in = 17'(sx);
            ts_in = 17'(sy);
         end
         2'd1: begin
            tc_in = -17'(sy);
            ts_in = 17'(sx);
         end
         2'd2: begin
            tc_in = -17'(sx);
            ts_in = -17'(sy);
         end
         default: begin
            tc_in = 17'(sy);
            ts_in = -17'(sx);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else if (adv) begin
         tv_ff <= cv_ff[NI];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tm_ff <= cm_ff[NI];
         tc_ff <= tc_in;
         ts_ff <= ts_in;
      end
   end

   // ---- range times trig magnitude, scaled by 2^-15 ----
   assign mag[0]  = tc_ff[16] ? 16'(-tc_ff) : tc_ff[15:0];
   assign mag[1]  = ts_ff[16] ? 16'(-ts_ff) : ts_ff[15:0];
   assign prod[0] = 32'(tm_ff.range_mm) * 32'(mag[0]);
   assign prod[1] = 32'(tm_ff.range_mm) * 32'(mag[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= tv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dm_ff[0]     <= tm_ff;
         dn_ff[0][0]  <= prod[0][30:15];
         dn_ff[0][1]  <= prod[1][30:15];
         dr_ff[0][0]  <= '0;
         dr_ff[0][1]  <= '0;
         dq_ff[0][0]  <= '0;
         dq_ff[0][1]  <= '0;
         dsg_ff[0][0] <= tc_ff[16];
         dsg_ff[0][1] <= ts_ff[16];
      end
   end

   // ---- restoring divide by cell size, one quotient bit per stage ----
   for (genvar k = 0; k < NQ; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) dm_ff[k+1] <= dm_ff[k];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         assign trial[k][l] = {dr_ff[k][l], dn_ff[k][l][15]};

         always_ff @(posedge clock) begin
            if (adv) begin
               dn_ff[k+1][l]  <= {dn_ff[k][l][14:0], 1'b0};
               dsg_ff[k+1][l] <= dsg_ff[k][l];
               if (trial[k][l] >= {1'b0, den}) begin
                  dr_ff[k+1][l] <= 16'(trial[k][l] - {1'b0, den});
                  dq_ff[k+1][l] <= {dq_ff[k][l][14:0], 1'b1};
               end else begin
                  dr_ff[k+1][l] <= trial[k][l][15:0];
                  dq_ff[k+1][l] <= {dq_ff[k][l][14:0], 1'b0};
               end
            end
         end
      end
   end

   // ---- sign, center offset, bounds and address ----
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         pos[l] = dsg_ff[NQ][l] ? -$signed({4'b0000, dq_ff[NQ][l]})
                                :  $signed({4'b0000, dq_ff[NQ][l]});
      end
      pos[0]  = pos[0] + $signed(20'(GRID_W / 2));
      pos[1]  = pos[1] + $signed(20'(GRID_H / 2));
      in_x    = !pos[0][19] && (pos[0] < $signed(20'(GRID_W)));
      in_y    = !pos[1][19] && (pos[1] < $signed(20'(GRID_H)));
      mark_in = dm_ff[NQ].ok && in_x && in_y;
      rdok_in = dm_ff[NQ].cmd && (32'(dm_ff[NQ].read_x) < 32'(GRID_W))
                && (32'(dm_ff[NQ].read_y) < 32'(GRID_H));
      if (mark_in) begin
         addr_in = AW'(pos[1][YW-1:0]) * GW_A + AW'(pos[0][XW-1:0]);
      end else begin
         addr_in = AW'(dm_ff[NQ].read_y) * GW_A + AW'(dm_ff[NQ].read_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (adv) begin
         av_ff <= dv_ff[NQ];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_cmd_ff  <= dm_ff[NQ].cmd;
         a_mark_ff <= mark_in;
         a_rdok_ff <= rdok_in;
         a_addr_ff <= addr_in;
         a_x_ff    <= pos[0][COORD_W-1:0];
         a_y_ff    <= pos[1][COORD_W-1:0];
      end
   end

   // ---- grid store: clear sweep after reset, then mark and read ----
   assign mem_we = clr_busy_ff || (adv && av_ff && a_mark_ff);
   assign mem_wa = clr_busy_ff ? clr_cnt_ff : a_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(DEPTH - 1)) clr_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_wa] <= !clr_busy_ff;
      if (adv) grid_q_ff <= grid_mem[a_addr_ff];
   end

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= av_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_marked_ff <= a_mark_ff;
         rsp_rd_ff     <= a_rdok_ff;
         rsp_x_ff      <= a_mark_ff ? a_x_ff : '0;
         rsp_y_ff      <= a_mark_ff ? a_y_ff : '0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.marked        = rsp_marked_ff;
   assign rsp_bus.cell_x        = rsp_x_ff;
   assign rsp_bus.cell_y        = rsp_y_ff;
   assign rsp_bus.cell_occupied = rsp_rd_ff && grid_q_ff;

   `LSGM_ASSERT_IMPL(a_clear_pipe_empty, clr_busy_ff, !cv_ff[0] && !av_ff && !rsp_valid_ff)
   `LSGM_ASSERT_IMPL(a_mark_only_sample, av_ff && a_mark_ff, !a_cmd_ff && !a_rdok_ff)
   `LSGM_ASSERT_NEXT(a_mark_gives_word, adv && av_ff && a_mark_ff, rsp_valid_ff && rsp_marked_ff && !rsp_rd_ff)

endmodule

/* hdl/laser_scan_grid_marker.sv */
// ----------------------------------------------------------------------------
// Laser scan grid marker
// Marks laser range endpoints as occupied cells and reads back single cells.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | word
//  req_bus | in  | valid/ready | cmd, range_finite, range_mm, beam_index, read_x, read_y
//  rsp_bus | out | valid/ready | marked, cell_x, cell_y, cell_occupied
//  csr_bus | in  | valid/ready | index, data (always ready)
//
//  One word per cycle sustained while rsp_bus is ready; each word passes the 16-stage
//  CORDIC, the 16-stage cell divider and the grid store read.
//  After reset the grid store is swept to unknown, all GRID_W*GRID_H cells
//  (16384 at default size); req_bus.ready stays low meanwhile.
//  A stalled rsp_bus freezes the back; the front keeps filling a 4-word queue.
// ----------------------------------------------------------------------------
module laser_scan_grid_marker import lsgm_pkg::*; #(
   parameter int GRID_W    = GRID_W_DEF,
   parameter int GRID_H    = GRID_H_DEF,
   parameter int MAX_BEAMS = MAX_BEAMS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lsgm_req_if.sink   req_bus,
   lsgm_rsp_if.source rsp_bus,
   lsgm_csr_if.sink   csr_bus
);

   cfg_type  cfg_ff;
   item_type push_data;
   item_type q_item;
   logic     push;
   logic     q_ready;
   logic     q_valid;
   logic     q_take;
   logic     clr_busy;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rng_lo     <= RANGE_MIN_RST;
         cfg_ff.rng_hi     <= RANGE_MAX_RST;
         cfg_ff.angle_step <= ANGLE_STEP_RST;
         cfg_ff.cell_size  <= CELL_SIZE_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_RANGE_MIN:  cfg_ff.rng_lo     <= csr_bus.data[15:0];
            CSR_RANGE_MAX:  cfg_ff.rng_hi     <= csr_bus.data[15:0];
            CSR_ANGLE_STEP: cfg_ff.angle_step <= csr_bus.data[23:0];
            CSR_CELL_SIZE:  cfg_ff.cell_size  <= csr_bus.data[15:0];
            default: ;
         endcase
      end
   end

   lsgm_front #(
      .MAX_BEAMS (MAX_BEAMS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .hold      (clr_busy),
      .req_bus   (req_bus),
      .push      (push),
      .push_data (push_data),
      .q_ready   (q_ready)
   );

   lsgm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (q_ready),
      .pop       (q_take),
      .out_valid (q_valid),
      .out_data  (q_item)
   );

   lsgm_back #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take),
      .clr_busy (clr_busy),
      .rsp_bus  (rsp_bus)
   );

endmodule

/* tb/sv/laser_scan_grid_marker_test.sv */
// ----------------------------------------------------------------------------
// Laser scan grid marker testbench
// Drives range samples and cell reads with random gaps and stalls, predicts
// every response word from an own CORDIC and grid model, and checks in order.
// ----------------------------------------------------------------------------
module laser_scan_grid_marker_test;
   import lsgm_pkg::*;

   typedef struct {
      bit        marked;
      bit [6:0]  cell_x;
      bit [6:0]  cell_y;
      bit        cell_occupied;
   } cell_word_type;

   class grid_scoreboard;
      bit            grid [16384];
      bit [15:0]     rmin, rmax, csize;
      bit [23:0]     astep;
      cell_word_type pending [$];
      int            mismatches;

      function void clear();
         foreach (grid[i]) grid[i] = 0;
         rmin = RANGE_MIN_RST; rmax = RANGE_MAX_RST;
         astep = ANGLE_STEP_RST; csize = CELL_SIZE_RST;
      endfunction

      function void write_reg(csr_index_type idx, bit [23:0] v);
         case (idx)
            CSR_RANGE_MIN: rmin = v[15:0];
            CSR_RANGE_MAX: rmax = v[15:0];
            CSR_ANGLE_STEP: astep = v;
            CSR_CELL_SIZE: csize = v[15:0];
            default: ;
         endcase
      endfunction

      function void sin_cos(bit [23:0] phase, output int c, output int s);
         int x, y, z, dx, dy;
         x = 19898; y = 0; z = int'(phase[21:0]);
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= int'(ATAN_TABLE[i]);
            end else begin
               x += dx; y -= dy; z += int'(ATAN_TABLE[i]);
            end
         end
         x = x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
         y = y > 32767 ? 32767 : (y < -32768 ? -32768 : y);
         case (phase[23:22])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
      endfunction

      function void note_request(bit cmd, bit fin, bit [15:0] rng, bit [11:0] beam,
                                 bit [6:0] rx, bit [6:0] ry);
         cell_word_type w;
         bit [35:0]     prod;
         longint        den, cx, cy;
         int            c, s;
         w = '{0, 0, 0, 0};
         if (cmd) begin
            w.cell_occupied = grid[{ry, rx}];
         end else if (fin && rng > rmin && rng < rmax) begin
            prod = beam * astep;
            sin_cos(prod[23:0], c, s);
            den = longint'(csize == 0 ? 1 : csize) * 32768;
            cx = (longint'(rng) * c) / den + 64;
            cy = (longint'(rng) * s) / den + 64;
            if (cx >= 0 && cx < 128 && cy >= 0 && cy < 128) begin
               grid[cy * 128 + cx] = 1;
               w.marked = 1; w.cell_x = cx[6:0]; w.cell_y = cy[6:0];
            end
         end
         pending.push_back(w);
      endfunction

      function void check_word(bit m, bit [6:0] x, bit [6:0] y, bit o);
         cell_word_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word m=%0d x=%0d y=%0d o=%0d", m, x, y, o);
            return;
         end
         e = pending.pop_front();
         if (e.marked !== m || e.cell_x !== x || e.cell_y !== y || e.cell_occupied !== o) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp m=%0d x=%0d y=%0d o=%0d got m=%0d x=%0d y=%0d o=%0d",
                        e.marked, e.cell_x, e.cell_y, e.cell_occupied, m, x, y, o);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   lsgm_req_if req_bus ();
   lsgm_rsp_if rsp_bus ();
   lsgm_csr_if csr_bus ();
   grid_scoreboard board = new();
   int hold_cycles = 0;
   bit drain_wait = 0;

   laser_scan_grid_marker i_dut (.clock, .reset, .req_bus, .rsp_bus, .csr_bus);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_bus.valid = 0; req_bus.cmd = 0; req_bus.range_finite = 0; req_bus.range_mm = 0;
      req_bus.beam_index = 0; req_bus.read_x = 0; req_bus.read_y = 0;
      csr_bus.valid = 0; csr_bus.index = 0; csr_bus.data = 0;
      rsp_bus.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_word(rsp_bus.marked, rsp_bus.cell_x, rsp_bus.cell_y, rsp_bus.cell_occupied);
   end

   // response side: random stalls, long hold-off on request
   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (drain_wait) gap = 0;
         if (gap > 0) begin
            rsp_bus.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   task automatic write_reg(csr_index_type idx, bit [23:0] v);
      csr_bus.valid <= 1; csr_bus.index <= idx; csr_bus.data <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 0;
      board.write_reg(idx, v);
   endtask

   task automatic wait_drained();
      drain_wait = 1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      drain_wait = 0;
   endtask

   task automatic send_word(bit cmd, bit fin, bit [15:0] rng, bit [11:0] beam,
                            bit [6:0] rx, bit [6:0] ry, bit gaps);
      int gap;
      gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1; req_bus.cmd <= cmd; req_bus.range_finite <= fin;
      req_bus.range_mm <= rng; req_bus.beam_index <= beam;
      req_bus.read_x <= rx; req_bus.read_y <= ry;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(cmd, fin, rng, beam, rx, ry);
   endtask

   task automatic idle_req();
      req_bus.valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      bit [15:0] rng;
      for (int n = 0; n < count; n++) begin
         if (n == count / 3) hold_cycles = 400;
         if ($urandom_range(0, 3) == 0) begin
            send_word(1, $urandom, $urandom, $urandom,
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                : 64 + $urandom_range(0, 8) - 4,
                      $urandom, n % 7 != 0);
         end else begin
            rng = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(90, 7000);
            send_word(0, $urandom_range(0, 9) != 0, rng, $urandom, $urandom, $urandom,
                      n % 7 != 0);
         end
      end
      idle_req();
      wait_drained();
   endtask

   initial begin
      board.clear();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, both commands, special cases
      send_word(1, 0, 0, 0, 64, 64, 0);
      send_word(0, 1, 1000, 0, 0, 0, 0);
      send_word(1, 0, 0, 0, 74, 64, 0);
      send_word(0, 0, 1000, 5, 0, 0, 0);
      send_word(0, 1, 100, 5, 0, 0, 0);
      send_word(0, 1, 101, 5, 0, 0, 0);
      send_word(0, 1, 29999, 7, 0, 0, 0);
      send_word(0, 1, 30000, 7, 0, 0, 0);
      send_word(0, 1, 16'hffff, 12'hfff, 7'h7f, 7'h7f, 0);
      send_word(0, 1, 6300, 12'hfff, 0, 0, 0);
      send_word(0, 1, 6399, 180, 0, 0, 0);
      send_word(0, 1, 6400, 90, 0, 0, 0);
      send_word(1, 1, 16'hffff, 12'hfff, 127, 127, 0);
      send_word(1, 0, 0, 0, 0, 0, 0);
      idle_req();
      wait_drained();
      write_reg(CSR_CELL_SIZE, 0);
      write_reg(CSR_RANGE_MIN, 0);
      write_reg(CSR_RANGE_MAX, 16'hffff);
      write_reg(CSR_ANGLE_STEP, 24'hffffff);
      send_word(0, 1, 1, 1, 0, 0, 0);
      send_word(0, 1, 40, 12'h800, 0, 0, 0);
      send_word(0, 1, 63, 12'hfff, 0, 0, 0);
      send_word(1, 0, 0, 0, 63, 64, 0);
      idle_req();
      wait_drained();
      write_reg(CSR_CELL_SIZE, 16'hffff);
      write_reg(CSR_ANGLE_STEP, 24'h400000);
      send_word(0, 1, 16'hfffe, 1, 0, 0, 0);
      send_word(0, 1, 16'hfffe, 3, 0, 0, 0);
      idle_req();
      wait_drained();
      // random phases under several settings
      write_reg(CSR_RANGE_MIN, RANGE_MIN_RST);
      write_reg(CSR_RANGE_MAX, RANGE_MAX_RST);
      write_reg(CSR_ANGLE_STEP, ANGLE_STEP_RST);
      write_reg(CSR_CELL_SIZE, CELL_SIZE_RST);
      random_phase(150);
      write_reg(CSR_CELL_SIZE, $urandom_range(20, 60));
      write_reg(CSR_ANGLE_STEP, $urandom);
      write_reg(CSR_RANGE_MIN, $urandom_range(0, 200));
      write_reg(CSR_RANGE_MAX, $urandom_range(3000, 65535));
      random_phase(150);
      write_reg(CSR_CELL_SIZE, $urandom_range(1, 20));
      write_reg(CSR_ANGLE_STEP, $urandom_range(1, 100000));
      random_phase(150);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
